@@ sv/hlb_pkg.sv @@
package hlb_pkg;

  // Receiver channel value, center threshold, delay and time stamp widths
  localparam int CHAN_W   = 11;
  localparam int CENTER_W = 12;
  localparam int DELAY_W  = 16;
  localparam int STAMP_W  = 32;

  // Input and output word widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEARBOX_CENTER    = 3'd0,
    REG_FRONT_LOCK_CENTER = 3'd1,
    REG_REAR_LOCK_CENTER  = 3'd2,
    REG_INVERT_MASK       = 3'd3,
    REG_BLINK_ON_MS       = 3'd4,
    REG_BLINK_OFF_MS      = 3'd5,
    REG_CHANNELS_ASSIGNED = 3'd6
  } cfg_reg_t;

  // Blink timing settings handed to the phase generator
  typedef struct packed {
    logic [DELAY_W-1:0] on_ms;
    logic [DELAY_W-1:0] off_ms;
  } blink_cfg_t;

endpackage

@@ sv/hlb_chan.sv @@
module hlb_chan import hlb_pkg::*; (
  input  logic [CHAN_W-1:0]   raw,
  input  logic                invert,
  input  logic [CENTER_W-1:0] center,
  output logic                below
);

  // Inverted value is 2048 - v, which needs one bit more than the raw value
  localparam logic [CENTER_W-1:0] INV_BASE = CENTER_W'(2048);

  logic [CENTER_W-1:0] value;

  assign value = invert ? (INV_BASE - {1'b0, raw}) : {1'b0, raw};
  assign below = value < center;

endmodule

@@ sv/hlb_blink.sv @@
module hlb_blink import hlb_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 failsafe,
  input  blink_cfg_t           cfg,
  output logic                 phase_next
);

  logic [TIME_BITS-1:0] on_deadline, on_deadline_next;
  logic [TIME_BITS-1:0] off_deadline, off_deadline_next;
  logic                 phase_lit;
  logic                 on_hit, off_hit;
  logic [DELAY_W-1:0]   delay;

  // A zero deadline is disarmed; the on deadline wins when both expire
  assign on_hit  = (on_deadline != '0) && (now > on_deadline);
  assign off_hit = (off_deadline != '0) && (now > off_deadline);

  // Phase that starts under failsafe runs for half its delay
  always_comb begin
    priority if (on_hit) begin
      delay = failsafe ? (cfg.off_ms >> 1) : cfg.off_ms;
    end else begin
      delay = failsafe ? (cfg.on_ms >> 1) : cfg.on_ms;
    end
  end

  always_comb begin
    priority if (on_hit) begin
      on_deadline_next  = '0;
      off_deadline_next = now + TIME_BITS'(delay);
      phase_next        = 1'b0;
    end else if (off_hit) begin
      off_deadline_next = '0;
      on_deadline_next  = now + TIME_BITS'(delay);
      phase_next        = 1'b1;
    end else begin
      on_deadline_next  = on_deadline;
      off_deadline_next = off_deadline;
      phase_next        = phase_lit;
    end
  end

  // Deadline and phase state advance on each step, at most once per processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      on_deadline  <= '0;
      off_deadline <= TIME_BITS'(1);
      phase_lit    <= 1'b0;
    end else if (step) begin
      on_deadline  <= on_deadline_next;
      off_deadline <= off_deadline_next;
      phase_lit    <= phase_next;
    end
  end

endmodule

@@ sv/hazard_light_blinker.sv @@
// Hazard lamp controller.
// Input stream s_*: one word per receiver sample carrying gearbox, front
// lock and rear lock channel values, the failsafe flag and a millisecond
// time stamp. Output stream m_*: one word per input word with the front and
// rear lamp levels after that sample. Settings are loaded through the
// cfg_we / cfg_index / cfg_data write port; the user must write them only
// while the stream is idle, as the block does not enforce it. The input
// register loads at the accepting edge and the result register when the
// word advances, which waits while an unaccepted result is held. Throughput
// is one word per cycle while m_tready stays high; the deadline and phase
// state update at most once per word. While m_tready is low with a result
// held, the input register takes a word only if empty, then s_tready drops.
// Reset clears both stream stages, restores the default settings, disarms
// the on deadline, arms the off deadline at one and turns both lamps off.
// With channels unassigned, each word returns the held lamp levels and no
// state changes.
module hazard_light_blinker import hlb_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // gearbox_value[10:0], front_lock_value[21:11], rear_lock_value[32:22],
  // failsafe[33], now_ms[65:34], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // front_hazard_level[0], rear_hazard_level[1], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Settings
  logic [CENTER_W-1:0] gearbox_center, front_lock_center, rear_lock_center;
  logic [2:0]          invert_mask;
  blink_cfg_t          blink_cfg;
  logic                channels_assigned;

  always_ff @(posedge clk) begin
    if (rst) begin
      gearbox_center    <= CENTER_W'(1024);
      front_lock_center <= CENTER_W'(1024);
      rear_lock_center  <= CENTER_W'(1024);
      invert_mask       <= '0;
      blink_cfg.on_ms   <= DELAY_W'(500);
      blink_cfg.off_ms  <= DELAY_W'(500);
      channels_assigned <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GEARBOX_CENTER:    gearbox_center    <= cfg_data[CENTER_W-1:0];
        REG_FRONT_LOCK_CENTER: front_lock_center <= cfg_data[CENTER_W-1:0];
        REG_REAR_LOCK_CENTER:  rear_lock_center  <= cfg_data[CENTER_W-1:0];
        REG_INVERT_MASK:       invert_mask       <= cfg_data[2:0];
        REG_BLINK_ON_MS:       blink_cfg.on_ms   <= cfg_data;
        REG_BLINK_OFF_MS:      blink_cfg.off_ms  <= cfg_data;
        REG_CHANNELS_ASSIGNED: channels_assigned <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                 in_valid;
  logic [CHAN_W-1:0]    in_gearbox, in_front, in_rear;
  logic                 in_failsafe;
  logic [STAMP_W-1:0]   in_now;
  logic                 advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_gearbox  <= s_tdata[10:0];
      in_front    <= s_tdata[21:11];
      in_rear     <= s_tdata[32:22];
      in_failsafe <= s_tdata[33];
      in_now      <= s_tdata[65:34];
    end
  end

  // Time stamp masked or zero extended to the deadline width
  logic [TIME_BITS-1:0] now;

  generate
    if (TIME_BITS > STAMP_W) begin : g_now_ext
      assign now = {{(TIME_BITS-STAMP_W){1'b0}}, in_now};
    end else begin : g_now_cut
      assign now = in_now[TIME_BITS-1:0];
    end
  endgenerate

  // Channel compares
  logic gb_low, fl_low, rl_low;

  hlb_chan u_gearbox (
    .raw(in_gearbox), .invert(invert_mask[0]), .center(gearbox_center), .below(gb_low)
  );
  hlb_chan u_front (
    .raw(in_front), .invert(invert_mask[1]), .center(front_lock_center), .below(fl_low)
  );
  hlb_chan u_rear (
    .raw(in_rear), .invert(invert_mask[2]), .center(rear_lock_center), .below(rl_low)
  );

  // Blink phase
  logic step, phase_next;

  assign step = advance && channels_assigned;

  hlb_blink #(.TIME_BITS(TIME_BITS)) u_blink (
    .clk(clk), .rst(rst), .step(step), .now(now), .failsafe(in_failsafe),
    .cfg(blink_cfg), .phase_next(phase_next)
  );

  // Lamp levels
  logic front_level, rear_level, front_next, rear_next;
  logic blink_f, blink_r, front_base, rear_base;

  always_comb begin
    if (gb_low) begin
      blink_f    = 1'b0;
      blink_r    = 1'b0;
      front_base = fl_low;
      rear_base  = rl_low;
    end else begin
      blink_f    = fl_low;
      blink_r    = rl_low;
      front_base = fl_low ? front_level : 1'b1;
      rear_base  = rl_low ? rear_level : 1'b1;
    end
    front_next = (blink_f || in_failsafe) ? phase_next : front_base;
    rear_next  = (blink_r || in_failsafe) ? phase_next : rear_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_level <= 1'b0;
      rear_level  <= 1'b0;
    end else if (step) begin
      front_level <= front_next;
      rear_level  <= rear_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (channels_assigned) begin
        m_tdata <= {{(OUT_DATA_W-2){1'b0}}, rear_next, front_next};
      end else begin
        m_tdata <= {{(OUT_DATA_W-2){1'b0}}, rear_level, front_level};
      end
    end
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  import hlb_pkg::*;

  // No register answers at this index; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 4;
  localparam int DIR_N        = 20;

  // One receiver sample, laid out as it travels in s_tdata (gearbox lowest)
  typedef struct packed {
    logic [STAMP_W-1:0] now;
    logic               fs;
    logic [CHAN_W-1:0]  rl;
    logic [CHAN_W-1:0]  fl;
    logic [CHAN_W-1:0]  gb;
  } sample_t;

  typedef struct packed {
    logic rear;
    logic front;
  } lamps_t;

  // Directed row: sample plus an optional hand-written expectation
  typedef struct packed {
    logic    typed;
    lamps_t  lamps;
    sample_t s;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid;
  logic                  s_tready;
  // gearbox_value[10:0], front_lock_value[21:11], rear_lock_value[32:22],
  // failsafe[33], now_ms[65:34], zero fill
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  // front_hazard_level[0], rear_hazard_level[1], zero fill
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Lamp model: settings
  logic [CENTER_W-1:0] gear_ctr, front_ctr, rear_ctr;
  logic [2:0]          inv_mask;
  logic [DELAY_W-1:0]  lit_ms, dark_ms;
  logic                chans_on;
  // Lamp model: blink timing and held levels
  logic [STAMP_W-1:0]  lit_until, dark_until;
  logic                lit;
  logic                front_lvl, rear_lvl;

  lamps_t   lamp_q[$];
  lamps_t   want;
  int       errs = 0;
  bit       steady = 1'b0;
  bit       hold_req = 1'b0;
  logic [STAMP_W-1:0] cur_ms;
  dir_row_t dir_tab [DIR_N];

  hazard_light_blinker i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case a word never comes back
  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Channel value after optional inversion (2048 - v)
  function automatic logic [CENTER_W-1:0] chan_level(logic [CHAN_W-1:0] raw, logic inv);
    return inv ? 12'd2048 - {1'b0, raw} : {1'b0, raw};
  endfunction

  // Advance the lamp model by one sample and return the levels it shows
  function automatic lamps_t lamp_step(sample_t s);
    logic [CENTER_W-1:0] gb, fl, rl;
    logic               fl_low, rl_low, blink_f, blink_r;
    logic [DELAY_W-1:0] d;
    lamps_t             res;
    if (chans_on) begin
      gb = chan_level(s.gb, inv_mask[0]);
      fl = chan_level(s.fl, inv_mask[1]);
      rl = chan_level(s.rl, inv_mask[2]);
      fl_low = fl < front_ctr;
      rl_low = rl < rear_ctr;
      if (gb < gear_ctr) begin
        blink_f = 1'b0;
        blink_r = 1'b0;
        front_lvl = fl_low;
        rear_lvl = rl_low;
      end else begin
        blink_f = fl_low;
        blink_r = rl_low;
        if (!fl_low) front_lvl = 1'b1;
        if (!rl_low) rear_lvl = 1'b1;
      end
      if (s.fs) begin
        blink_f = 1'b1;
        blink_r = 1'b1;
      end
      // Lit deadline wins over the dark one; zero means disarmed
      if (lit_until != 0 && s.now > lit_until) begin
        d = s.fs ? dark_ms >> 1 : dark_ms;
        lit_until = '0;
        dark_until = s.now + {{(STAMP_W-DELAY_W){1'b0}}, d};
        lit = 1'b0;
      end else if (dark_until != 0 && s.now > dark_until) begin
        d = s.fs ? lit_ms >> 1 : lit_ms;
        dark_until = '0;
        lit_until = s.now + {{(STAMP_W-DELAY_W){1'b0}}, d};
        lit = 1'b1;
      end
      if (blink_f) front_lvl = lit;
      if (blink_r) rear_lvl = lit;
    end
    res.front = front_lvl;
    res.rear = rear_lvl;
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Raw channel value, biased toward the (possibly inverted) center
  function automatic logic [CHAN_W-1:0] chan_pick(logic [CENTER_W-1:0] ctr, logic inv);
    int t;
    int r;
    logic [31:0] v;
    t = inv ? 2048 - int'(ctr) : int'(ctr);
    r = $urandom_range(0, 99);
    if (r < 50) return CHAN_W'($urandom_range(0, 2047));
    if (r < 85) begin
      t = t + int'($urandom_range(0, 6)) - 3;
      if (t < 0) t = 0;
      if (t > 2047) t = 2047;
      v = t;
      return v[CHAN_W-1:0];
    end
    return r[0] ? {CHAN_W{1'b1}} : {CHAN_W{1'b0}};
  endfunction

  // Random sample; time runs forward unless noise lets it jump anywhere
  function automatic sample_t rand_sample(bit noise, int span);
    sample_t s;
    int r;
    r = $urandom_range(0, 99);
    if (noise && r < 25) s.now = $urandom;
    else if (noise && r < 30) s.now = r[0] ? {STAMP_W{1'b1}} : {STAMP_W{1'b0}};
    else begin
      if (r < 70) cur_ms = cur_ms + $urandom_range(0, span / 4 + 1);
      else if (r < 97) cur_ms = cur_ms + $urandom_range(0, 3);
      else cur_ms = cur_ms + $urandom_range(0, 32'hF_FFFF);
      s.now = cur_ms;
    end
    s.gb = chan_pick(gear_ctr, inv_mask[0]);
    s.fl = chan_pick(front_ctr, inv_mask[1]);
    s.rl = chan_pick(rear_ctr, inv_mask[2]);
    s.fs = ($urandom_range(0, 99) < 20);
    return s;
  endfunction

  function automatic dir_row_t mk_row(logic [CHAN_W-1:0] gb, fl, rl, logic fs,
                                      logic [STAMP_W-1:0] now, logic typed,
                                      logic front, logic rear);
    dir_row_t d;
    d.s.gb = gb;
    d.s.fl = fl;
    d.s.rl = rl;
    d.s.fs = fs;
    d.s.now = now;
    d.typed = typed;
    d.lamps.front = front;
    d.lamps.rear = rear;
    return d;
  endfunction

  // Register write; the model takes it at once since the block is idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GEARBOX_CENTER:    gear_ctr = data[CENTER_W-1:0];
      REG_FRONT_LOCK_CENTER: front_ctr = data[CENTER_W-1:0];
      REG_REAR_LOCK_CENTER:  rear_ctr = data[CENTER_W-1:0];
      REG_INVERT_MASK:       inv_mask = data[2:0];
      REG_BLINK_ON_MS:       lit_ms = data[DELAY_W-1:0];
      REG_BLINK_OFF_MS:      dark_ms = data[DELAY_W-1:0];
      REG_CHANNELS_ASSIGNED: chans_on = data[0];
      default: ;
    endcase
  endtask

  // Offer one word after a random gap; record what it should give back
  task automatic send_sample(input sample_t s, input logic typed, input lamps_t typed_val);
    int gap;
    lamps_t p;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W-$bits(sample_t)){1'b0}}, s};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = lamp_step(s);
    lamp_q.push_back(typed ? typed_val : p);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (lamp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Load every register, then stream n random words
  task automatic run_phase(input logic [CENTER_W-1:0] gc, fc, rc, input logic [2:0] inv,
                           input logic [DELAY_W-1:0] on_ms, off_ms, input logic asg,
                           input int n, input bit noise, input bit hold);
    logic [CFG_DATA_W-1:0] rnd;
    int span;
    lamps_t none;
    none = '0;
    rnd = $urandom;
    cfg_write(REG_GEARBOX_CENTER, {rnd[15:12], gc});
    rnd = $urandom;
    cfg_write(REG_FRONT_LOCK_CENTER, {rnd[15:12], fc});
    rnd = $urandom;
    cfg_write(REG_REAR_LOCK_CENTER, {rnd[15:12], rc});
    rnd = $urandom;
    cfg_write(REG_INVERT_MASK, {rnd[15:3], inv});
    cfg_write(REG_BLINK_ON_MS, on_ms);
    cfg_write(REG_BLINK_OFF_MS, off_ms);
    rnd = $urandom;
    cfg_write(REG_CHANNELS_ASSIGNED, {rnd[15:1], asg});
    span = int'(on_ms) + int'(off_ms);
    if (span > 4000) span = 4000;
    if (hold) hold_req = 1'b1;
    for (int k = 0; k < n; k++) begin
      steady = (k % 120) < 25;
      send_sample(rand_sample(noise, span), 1'b0, none);
    end
    steady = 1'b0;
    drain();
  endtask

  // Result checker: each word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (lamp_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, m_tdata);
        errs++;
      end else begin
        want = lamp_q.pop_front();
        if (m_tdata[0] !== want.front) begin
          $display("%0t: front level expected %0b got %0b", $time, want.front, m_tdata[0]);
          errs++;
        end
        if (m_tdata[1] !== want.rear) begin
          $display("%0t: rear level expected %0b got %0b", $time, want.rear, m_tdata[1]);
          errs++;
        end
        if (m_tdata[OUT_DATA_W-1:2] !== '0) begin
          $display("%0t: fill bits expected 0 got %h", $time, m_tdata[OUT_DATA_W-1:2]);
          errs++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        int n;
        n = idle_len();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Main sequence
  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gear_ctr = 12'd1024;
    front_ctr = 12'd1024;
    rear_ctr = 12'd1024;
    inv_mask = 3'd0;
    lit_ms = 16'd500;
    dark_ms = 16'd500;
    chans_on = 1'b1;
    lit_until = '0;
    dark_until = 32'd1;
    lit = 1'b0;
    front_lvl = 1'b0;
    rear_lvl = 1'b0;

    // Directed table, default settings
    // gear low, locks at both ends; no deadline passed yet
    dir_tab[0]  = mk_row(11'd0, 11'd0, 11'd2047, 1'b0, 32'd0, 1'b1, 1'b1, 1'b0);
    // gear high, locks high: both steady on
    dir_tab[1]  = mk_row(11'd2047, 11'd2047, 11'd2047, 1'b0, 32'd1, 1'b1, 1'b1, 1'b1);
    // centers, one below and one at
    dir_tab[2]  = mk_row(11'd1023, 11'd1023, 11'd1024, 1'b0, 32'd1, 1'b1, 1'b1, 1'b0);
    dir_tab[3]  = mk_row(11'd1024, 11'd1024, 11'd1023, 1'b0, 32'd1, 1'b1, 1'b1, 1'b0);
    // blink: dark deadline passes, lit phase starts
    dir_tab[4]  = mk_row(11'd2047, 11'd0, 11'd0, 1'b0, 32'd2, 1'b1, 1'b1, 1'b1);
    dir_tab[5]  = mk_row(11'd2047, 11'd0, 11'd0, 1'b0, 32'd502, 1'b0, 1'b0, 1'b0);
    dir_tab[6]  = mk_row(11'd2047, 11'd0, 11'd0, 1'b0, 32'd503, 1'b0, 1'b0, 1'b0);
    // failsafe: both blink, halved phases
    dir_tab[7]  = mk_row(11'd0, 11'd2047, 11'd2047, 1'b1, 32'd1004, 1'b0, 1'b0, 1'b0);
    dir_tab[8]  = mk_row(11'd0, 11'd2047, 11'd2047, 1'b1, 32'd1255, 1'b0, 1'b0, 1'b0);
    // deadline wraps past the top of the time range
    dir_tab[9]  = mk_row(11'd2047, 11'd0, 11'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    dir_tab[10] = mk_row(11'd2047, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0);
    dir_tab[11] = mk_row(11'd2047, 11'd0, 11'd0, 1'b0, 32'd500, 1'b0, 1'b0, 1'b0);
    dir_tab[12] = mk_row(11'd0, 11'd2047, 11'd0, 1'b0, 32'd600, 1'b0, 1'b0, 1'b0);
    dir_tab[13] = mk_row(11'd1024, 11'd2047, 11'd2047, 1'b1, 32'd1001, 1'b0, 1'b0, 1'b0);
    dir_tab[14] = mk_row(11'd2047, 11'd1024, 11'd0, 1'b0, 32'd1252, 1'b0, 1'b0, 1'b0);
    dir_tab[15] = mk_row(11'd0, 11'd0, 11'd0, 1'b1, 32'd1753, 1'b0, 1'b0, 1'b0);
    // alternating bit patterns on every field
    dir_tab[16] = mk_row(11'h555, 11'h2AA, 11'h555, 1'b0, 32'h5555_5555, 1'b0, 1'b0, 1'b0);
    dir_tab[17] = mk_row(11'h2AA, 11'h555, 11'h2AA, 1'b1, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0);
    // wrap again, then bring the deadline back to small times
    dir_tab[18] = mk_row(11'd2047, 11'd0, 11'd2047, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    dir_tab[19] = mk_row(11'd1024, 11'd0, 11'd0, 1'b0, 32'd600, 1'b0, 1'b0, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_sample(dir_tab[i].s, dir_tab[i].typed, dir_tab[i].lamps);
    drain();
    cur_ms = 32'd600;

    // Fast blinking, default centers
    run_phase(12'd1024, 12'd1024, 12'd1024, 3'd0, 16'd20, 16'd30, 1'b1, 300, 1'b0, 1'b0);
    // Extreme centers, all inverted, zero lit time, longest dark time
    run_phase(12'd0, 12'd2048, 12'd4095, 3'd7, 16'd0, 16'hFFFF, 1'b1, 250, 1'b0, 1'b0);
    run_phase(12'd2048, 12'd0, 12'd1, 3'd5, 16'hFFFF, 16'd0, 1'b1, 250, 1'b0, 1'b0);
    // Write to an unused index must leave everything alone
    cfg_write(REG_NONE, 16'($urandom));
    run_phase(12'd700, 12'd1300, 12'd1024, 3'd2, 16'd1, 16'd1, 1'b1, 250, 1'b0, 1'b0);
    // Channels unassigned: levels and timing frozen
    run_phase(12'd900, 12'd100, 12'd2000, 3'd1, 16'd5, 16'd5, 1'b0, 150, 1'b0, 1'b0);
    // Back on, with a long receiver hold-off to fill the pipe
    run_phase(12'd1024, 12'd1024, 12'd1024, 3'd3, 16'd7, 16'd9, 1'b1, 300, 1'b0, 1'b1);
    // Time jumps anywhere, including backwards
    run_phase(12'd1500, 12'd512, 12'd2047, 3'd6, 16'd100, 16'd60, 1'b1, 380, 1'b1, 1'b0);

    if (errs == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
